@@ rtl/tilt_complementary_filter_assert.svh @@
// Assertion macros for the tilt complementary filter checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef TILT_COMPLEMENTARY_FILTER_ASSERT_SVH
`define TILT_COMPLEMENTARY_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCF_ASSERT_IMM(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcf: next-cycle check failed");

`endif

@@ rtl/tcf_pkg.sv @@
// Shared types, constants and helpers of the tilt complementary filter.
// Used by the top level, the iterative divider and the checker; no dependencies.
`timescale 1ns / 1ps

package tcf_pkg;

	// Stream payload widths (fields packed from bit 0, padded to bytes)
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 96;
	localparam int CFG_W       = 16;

	// Fixed-point constants
	localparam int MS_PER_S      = 1000;
	localparam int WEIGHT_ONE    = 65536;
	localparam int DEG_SCALE_Q16 = 58671;
	localparam int RATE_SCALE    = 500;
	localparam int FUSE_BIAS     = 32768000;  // half of 65536 * 1000
	localparam int DEG_BIAS      = 32768;     // half of 65536
	localparam int GAIN_RESET    = 1024;      // 4.0 in Q8.8

	// Divider: signed dividend (must be even, two bits per cycle), unsigned divisor
	localparam int DIV_NUM_W = 36;
	localparam int DIV_DEN_W = 11;

	typedef struct packed {
		logic                        start;
		logic signed [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0]        divisor;
	} tcf_div_req_t;

	typedef struct packed {
		logic                        done;
		logic signed [DIV_NUM_W-1:0] quotient;
	} tcf_div_rsp_t;

	localparam logic signed [DIV_NUM_W-1:0] SAT_HI = DIV_NUM_W'(32767);
	localparam logic signed [DIV_NUM_W-1:0] SAT_LO = -DIV_NUM_W'(32768);

	// Clamp to the signed 16-bit range
	function automatic logic signed [15:0] sat16(input logic signed [DIV_NUM_W-1:0] x);
		if (x > SAT_HI)
			sat16 = 16'sh7FFF;
		else if (x < SAT_LO)
			sat16 = 16'sh8000;
		else
			sat16 = x[15:0];
	endfunction

endpackage

@@ rtl/tcf_div.sv @@
// Iterative signed floor divider, two quotient bits per cycle.
// Depends on tcf_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module tcf_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tcf_pkg::tcf_div_req_t req,
	output tcf_pkg::tcf_div_rsp_t rsp
);
	import tcf_pkg::*;

	localparam int STEPS = DIV_NUM_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_q;
	logic [DIV_NUM_W-1:0] mag_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] mag_nx;
	logic [DIV_DEN_W-1:0] rem_nx;
	logic signed [DIV_NUM_W-1:0] q_pos;

	// Two restoring steps per cycle
	always_comb begin
		logic [DIV_DEN_W:0]   r;
		logic [DIV_NUM_W-1:0] m;
		r = {1'b0, rem_q};
		m = mag_q;
		for (int i = 0; i < 2; i++) begin
			r = {r[DIV_DEN_W-1:0], m[DIV_NUM_W-1]};
			m = {m[DIV_NUM_W-2:0], 1'b0};
			if (r >= {1'b0, den_q}) begin
				r    = r - {1'b0, den_q};
				m[0] = 1'b1;
			end
		end
		rem_nx = r[DIV_DEN_W-1:0];
		mag_nx = m;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[DIV_NUM_W-1];
			mag_q <= req.dividend[DIV_NUM_W-1] ? -req.dividend : req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			mag_q <= mag_nx;
			rem_q <= rem_nx;
		end
	end

	// Floor result: round the negative quotient down when a remainder is left
	assign q_pos = $signed(mag_q);
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q
		? $signed(-q_pos - $signed({{(DIV_NUM_W-1){1'b0}}, (rem_q != '0)}))
		: q_pos;

endmodule

@@ rtl/tilt_complementary_filter.sv @@
// Two-axis tilt complementary filter: top level with sequencer and shared multiplier.
// Depends on tcf_pkg and instantiates the iterative divider tcf_div.
`timescale 1ns / 1ps
//
//  channel  direction  handshake             payload
//  -------  ---------  --------------------  ------------------------------------------
//  cfg      in         cfg_valid/cfg_ready   cfg_data: blend_gain, unsigned Q8.8
//  s        in         s_tvalid/s_tready     s_tdata: dt, gyro rates, accel angles
//  m        out        m_tvalid/m_tready     m_tdata: angles, degrees, rates; m_tuser
//
//  An item uses the shared divider for five divisions (three when elapsed_ms is 0);
//  one multiplier, registered every cycle, carries all products in sequence.
//  s_tready is high only while the sequencer is idle; a waiting result does not block it.
//  A result that m does not take holds the sequencer in its final step.
//  Reset clears the fused angles and held rates to zero and loads blend_gain with 4.0.

module tilt_complementary_filter (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tcf_pkg::CFG_W-1:0]      cfg_data,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [9:0] elapsed_ms, [25:10] gyro_rate_xz, [41:26] gyro_rate_yz,
	// [57:42] accel_angle_xz, [73:58] accel_angle_yz, [79:74] zero
	input  logic [tcf_pkg::IN_TDATA_W-1:0] s_tdata,
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [15:0] angle_xz, [31:16] angle_yz, [47:32] degrees_xz, [63:48] degrees_yz,
	// [79:64] derived_rate_xz, [95:80] derived_rate_yz
	output logic [tcf_pkg::OUT_TDATA_W-1:0] m_tdata,
	// [0] rate_valid
	output logic                           m_tuser
);
	import tcf_pkg::*;

	localparam int MUL_A_W = 30;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int T_W     = 26;
	localparam int SHR_W   = PROD_W - 16;

	// Sequencer codes
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_WMUL = 5'd1;
	localparam logic [4:0] ST_WDIV = 5'd2;
	localparam logic [4:0] ST_DIV  = 5'd3;
	localparam logic [4:0] ST_WSAT = 5'd4;
	localparam logic [4:0] ST_M1   = 5'd5;
	localparam logic [4:0] ST_M2   = 5'd6;
	localparam logic [4:0] ST_M3   = 5'd7;
	localparam logic [4:0] ST_M4   = 5'd8;
	localparam logic [4:0] ST_M5   = 5'd9;
	localparam logic [4:0] ST_FDIV = 5'd10;
	localparam logic [4:0] ST_FSAT = 5'd11;
	localparam logic [4:0] ST_R1   = 5'd12;
	localparam logic [4:0] ST_RDIV = 5'd13;
	localparam logic [4:0] ST_RSAT = 5'd14;
	localparam logic [4:0] ST_DEG  = 5'd15;
	localparam logic [4:0] ST_DEGW = 5'd16;
	localparam logic [4:0] ST_OUT  = 5'd17;

	// Control and state
	logic [4:0]         state_q;
	logic [4:0]         ret_q;
	logic               axis_q;
	logic [CFG_W-1:0]   gain_q;
	logic signed [15:0] fused_q     [2];
	logic signed [15:0] last_rate_q [2];
	logic               m_tvalid_q;

	// Datapath
	logic [9:0]               dt_q;
	logic signed [15:0]       gyro_q  [2];
	logic signed [15:0]       accel_q [2];
	logic [16:0]              w_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [T_W-1:0]    t_q;
	logic signed [DIV_NUM_W-1:0] q_q;
	logic signed [15:0]       new_q [2];
	logic signed [15:0]       deg_q [2];
	logic [OUT_TDATA_W-1:0]   m_tdata_q;
	logic                     m_tuser_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [16:0]        diff;
	logic signed [PROD_W-1:0]  fuse_num;
	logic signed [PROD_W-1:0]  rate_num;
	logic signed [PROD_W-1:0]  deg_num;
	logic                      accept;
	logic                      out_load;
	tcf_div_req_t              div_req;
	tcf_div_rsp_t              div_rsp;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	// Hand the result to the output register once it is free or being emptied
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Angle change of the current axis for the derived rate
	assign diff = {new_q[axis_q][15], new_q[axis_q]} - {fused_q[axis_q][15], fused_q[axis_q]};

	// Fused numerator: (1-w)*P + w*accel*1000, biased for round to nearest
	assign fuse_num = acc_q + prod_q + $signed(PROD_W'(FUSE_BIAS));
	// Rate numerator: diff*500 + dt, divided by 2*dt
	assign rate_num = prod_q + $signed(PROD_W'(dt_q));
	assign deg_num  = prod_q + $signed(PROD_W'(DEG_BIAS));

	// Operand select of the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_WMUL: begin
				mul_a = $signed(MUL_A_W'(gain_q));
				mul_b = $signed(MUL_B_W'(dt_q));
			end
			ST_M1: begin
				mul_a = MUL_A_W'(fused_q[axis_q]);
				mul_b = MUL_B_W'(MS_PER_S);
			end
			ST_M2: begin
				mul_a = MUL_A_W'(gyro_q[axis_q]);
				mul_b = $signed(MUL_B_W'(dt_q));
			end
			ST_M3: begin
				mul_a = MUL_A_W'(accel_q[axis_q]);
				mul_b = MUL_B_W'(MS_PER_S);
			end
			ST_M4: begin
				mul_a = acc_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(WEIGHT_ONE) - $signed(MUL_B_W'(w_q));
			end
			ST_M5: begin
				mul_a = MUL_A_W'(t_q);
				mul_b = $signed(MUL_B_W'(w_q));
			end
			ST_R1: begin
				mul_a = MUL_A_W'(diff);
				mul_b = MUL_B_W'(RATE_SCALE);
			end
			ST_DEG: begin
				mul_a = MUL_A_W'(new_q[axis_q]);
				mul_b = MUL_B_W'(DEG_SCALE_Q16);
			end
			default: begin
			end
		endcase
	end

	// Divider requests: weight, fused angle, derived rate
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = DIV_DEN_W'(MS_PER_S);
		unique case (state_q)
			ST_WDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = $signed({prod_q[DIV_NUM_W-9:0], 8'b0});
			end
			ST_FDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = {{(DIV_NUM_W-SHR_W){fuse_num[PROD_W-1]}},
					fuse_num[PROD_W-1:16]};
			end
			ST_RDIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = rate_num[DIV_NUM_W-1:0];
				div_req.divisor  = {dt_q, 1'b0};
			end
			default: begin
			end
		endcase
	end

	tcf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer, configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ret_q          <= ST_IDLE;
			axis_q         <= 1'b0;
			gain_q         <= CFG_W'(GAIN_RESET);
			fused_q[0]     <= '0;
			fused_q[1]     <= '0;
			last_rate_q[0] <= '0;
			last_rate_q[1] <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				gain_q <= cfg_data;

			// Drop the result once taken, unless a new one replaces it
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_WMUL;
				end
				ST_WMUL: state_q <= ST_WDIV;
				ST_WDIV: begin
					ret_q   <= ST_WSAT;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done)
						state_q <= ret_q;
				end
				ST_WSAT: begin
					axis_q  <= 1'b0;
					state_q <= ST_M1;
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_M5;
				ST_M5: state_q <= ST_FDIV;
				ST_FDIV: begin
					ret_q   <= ST_FSAT;
					state_q <= ST_DIV;
				end
				ST_FSAT: begin
					axis_q  <= ~axis_q;
					state_q <= axis_q ? ST_R1 : ST_M1;
				end
				ST_R1: begin
					// Zero interval: hold both rates
					state_q <= (dt_q == '0) ? ST_DEG : ST_RDIV;
				end
				ST_RDIV: begin
					ret_q   <= ST_RSAT;
					state_q <= ST_DIV;
				end
				ST_RSAT: begin
					last_rate_q[axis_q] <= sat16(q_q);
					axis_q  <= ~axis_q;
					state_q <= axis_q ? ST_DEG : ST_R1;
				end
				ST_DEG: state_q <= ST_DEGW;
				ST_DEGW: begin
					axis_q  <= ~axis_q;
					state_q <= axis_q ? ST_OUT : ST_DEG;
				end
				ST_OUT: begin
					if (out_load) begin
						fused_q[0] <= new_q[0];
						fused_q[1] <= new_q[1];
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (div_rsp.done)
			q_q <= div_rsp.quotient;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					dt_q       <= s_tdata[9:0];
					gyro_q[0]  <= s_tdata[25:10];
					gyro_q[1]  <= s_tdata[41:26];
					accel_q[0] <= s_tdata[57:42];
					accel_q[1] <= s_tdata[73:58];
				end
			end
			ST_WSAT: begin
				// Cap the blend weight at 1.0
				if (q_q > $signed(DIV_NUM_W'(WEIGHT_ONE)))
					w_q <= 17'(WEIGHT_ONE);
				else
					w_q <= q_q[16:0];
			end
			ST_M2: acc_q <= prod_q;                      // angle * 1000
			ST_M3: acc_q <= acc_q + (prod_q <<< 2);      // + rate * dt * 4
			ST_M4: t_q   <= prod_q[T_W-1:0];             // accel * 1000
			ST_M5: acc_q <= prod_q;                      // (1 - w) * P
			ST_FSAT: new_q[axis_q] <= sat16(q_q);
			ST_DEGW: begin
				deg_q[axis_q] <= sat16({{(DIV_NUM_W-SHR_W){deg_num[PROD_W-1]}},
					deg_num[PROD_W-1:16]});
			end
			ST_OUT: begin
				if (out_load) begin
					m_tdata_q <= {last_rate_q[1], last_rate_q[0], deg_q[1], deg_q[0],
						new_q[1], new_q[0]};
					m_tuser_q <= (dt_q != '0);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/tcf_checker.sv @@
// Port-level checker for the tilt complementary filter, bound to the top level.
// Depends on tcf_pkg for widths and tilt_complementary_filter_assert.svh for macros.
`timescale 1ns / 1ps
`include "tilt_complementary_filter_assert.svh"

module tcf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tcf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);

	// A stalled result holds its payload
	`TCF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// An accepted transaction keeps the input side busy after acceptance
	`TCF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready ##1 !s_tready)

	// A new result only comes out of a busy sequencer
	`TCF_ASSERT_IMM(a_result_from_busy, $rose(m_tvalid), !$past(s_tready))

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

@@ dv/tb_top.sv @@
// Self-checking bench for tilt_complementary_filter: a directed stimulus table, then random
// phases across several blend gains, each result checked against a bit-exact fixed-point model
// or a pinned value; needs tcf_pkg for payload widths and the block's RTL, nothing else.
`timescale 1ns / 1ps

module tb_top;
	import tcf_pkg::*;

	localparam int RESET_CYCLES  = 12;
	// Time one item takes through the block; use it for the final hold-off
	localparam int ITEM_LATENCY  = 124;
	// Limit on the quiet stretch of a correct run, spanning a sender gap, an item and a sink stall
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS   = 170;
	localparam int N_DIRECTED    = 18;

	// Model arithmetic constants
	localparam longint UNITY_Q16       = 65536;
	localparam longint MS_PER_SEC      = 1000;
	localparam longint DEG_PER_RAD_Q16 = 58671;
	localparam longint RATE_SCALE      = 500;
	localparam logic [15:0] GAIN_AT_RESET = 16'd1024;

	// Input transaction, first field in the lowest bits
	typedef struct packed {
		logic [5:0]         pad;
		logic signed [15:0] accel_yz;
		logic signed [15:0] accel_xz;
		logic signed [15:0] gyro_yz;
		logic signed [15:0] gyro_xz;
		logic [9:0]         elapsed_ms;
	} imu_sample_t;

	// Output transaction payload, first field in the lowest bits
	typedef struct packed {
		logic signed [15:0] rate_yz;
		logic signed [15:0] rate_xz;
		logic signed [15:0] deg_yz;
		logic signed [15:0] deg_xz;
		logic signed [15:0] angle_yz;
		logic signed [15:0] angle_xz;
	} tilt_result_t;

	typedef struct packed {
		tilt_result_t fields;
		logic         rate_valid;
	} tilt_expect_t;

	typedef struct packed {
		logic [15:0]        gain;
		logic [9:0]         elapsed_ms;
		logic signed [15:0] gyro_xz;
		logic signed [15:0] gyro_yz;
		logic signed [15:0] accel_xz;
		logic signed [15:0] accel_yz;
		logic               pinned;
		tilt_expect_t       pinned_exp;
	} stim_row_t;

	localparam tilt_expect_t ZERO_HELD  = '0;
	localparam tilt_expect_t ZERO_FRESH = '{fields: '0, rate_valid: 1'b1};

	// Directed table: gain, dt, gyro xz/yz, accel xz/yz, typed result or predictor
	stim_row_t directed_rows [N_DIRECTED] = '{
		// right after reset with no elapsed time: everything is zero
		'{16'd1024, 10'd0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, ZERO_HELD},
		// zero elapsed time ignores gyro and accel entirely
		'{16'd1024, 10'd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b1, ZERO_HELD},
		// saturated weight pulls both angles onto a zero accel angle
		'{16'hFFFF, 10'd1023, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000, 1'b1, ZERO_FRESH},
		// saturated weight, accel at both extremes
		'{16'hFFFF, 10'd1023, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0, ZERO_HELD},
		// full swing in 4 ms: derived rates saturate
		'{16'hFFFF, 10'd4, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh7FFF, 1'b0, ZERO_HELD},
		// zero elapsed time holds the saturated rates
		'{16'd1024, 10'd0, 16'sh0064, -16'sh0064, 16'sh0000, 16'sh0000, 1'b0, ZERO_HELD},
		'{16'd1024, 10'd1, 16'sh03E8, -16'sh03E8, 16'sh1000, -16'sh1000, 1'b0, ZERO_HELD},
		'{16'd1024, 10'd20, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0, ZERO_HELD},
		// zero and tiny gain: gyro integration drives the angles into saturation and back out
		'{16'd0, 10'd1023, 16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000, 1'b0, ZERO_HELD},
		'{16'd0, 10'd1023, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b0, ZERO_HELD},
		'{16'd0, 10'd682, 16'sh5555, -16'sh2AAB, 16'sh5555, -16'sh2AAB, 1'b0, ZERO_HELD},
		'{16'd1, 10'd341, -16'sh5556, 16'sh2AAA, -16'sh5556, 16'sh2AAA, 1'b0, ZERO_HELD},
		// weight just below, exactly at and just above 1.0
		'{16'd1024, 10'd245, 16'sh0123, -16'sh0321, 16'sh0800, -16'sh0800, 1'b0, ZERO_HELD},
		'{16'd1024, 10'd250, -16'sh0123, 16'sh0321, -16'sh0800, 16'sh0800, 1'b0, ZERO_HELD},
		'{16'd1024, 10'd251, 16'sh0042, 16'sh0042, 16'sh1234, -16'sh1234, 1'b0, ZERO_HELD},
		'{16'h5555, 10'd1, 16'sh0FFF, -16'sh1000, 16'sh0001, -16'sh0001, 1'b0, ZERO_HELD},
		'{16'hAAAA, 10'd2, -16'sh0001, 16'sh0001, 16'sh7FFF, 16'sh7FFF, 1'b0, ZERO_HELD},
		'{16'd1024, 10'd0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, ZERO_HELD}
	};

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;

	// Model state and register copy
	logic [15:0]        gain_model     = GAIN_AT_RESET;
	logic signed [15:0] angle_xz_model = '0;
	logic signed [15:0] angle_yz_model = '0;
	logic signed [15:0] rate_xz_model  = '0;
	logic signed [15:0] rate_yz_model  = '0;

	tilt_expect_t pending_fusions [$];
	int           error_count = 0;
	int           idle_cycles = 0;
	logic [31:0]  cycle_count = '0;

	tilt_complementary_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------- model

	// Floor division for a positive divisor
	function automatic longint floor_quot(longint x, longint d);
		longint q;
		q = x / d;
		if (x - q * d < 0)
			q = q - 1;
		return q;
	endfunction

	// Round to nearest, ties toward plus infinity (d positive and even)
	function automatic longint round_quot(longint x, longint d);
		return floor_quot(x + d / 2, d);
	endfunction

	function automatic logic signed [15:0] clamp_s16(longint x);
		if (x > 32767)
			return 16'sh7FFF;
		if (x < -32768)
			return 16'sh8000;
		return x[15:0];
	endfunction

	// Blend one axis; the gyro prediction is kept exact at scale 1000
	function automatic logic signed [15:0] blend_axis(longint angle, longint rate,
			longint accel, longint dt, longint w);
		longint predicted;
		longint num;
		predicted = angle * MS_PER_SEC + rate * dt * 4;
		num = (UNITY_Q16 - w) * predicted + w * accel * MS_PER_SEC;
		return clamp_s16(round_quot(num, UNITY_Q16 * MS_PER_SEC));
	endfunction

	function automatic logic signed [15:0] to_sixtyfourths(logic signed [15:0] angle);
		return clamp_s16(round_quot(longint'(angle) * DEG_PER_RAD_Q16, UNITY_Q16));
	endfunction

	// Advance the filter state by one sample and return the result it produces
	function automatic tilt_expect_t advance_tilt_model(imu_sample_t smp);
		longint             dt;
		longint             w;
		logic signed [15:0] prev_xz;
		logic signed [15:0] prev_yz;
		tilt_expect_t       res;
		dt = longint'(smp.elapsed_ms);
		w = (longint'(gain_model) * dt * 256) / MS_PER_SEC;
		if (w > UNITY_Q16)
			w = UNITY_Q16;
		prev_xz = angle_xz_model;
		prev_yz = angle_yz_model;
		angle_xz_model = blend_axis(longint'(prev_xz), longint'(smp.gyro_xz),
			longint'(smp.accel_xz), dt, w);
		angle_yz_model = blend_axis(longint'(prev_yz), longint'(smp.gyro_yz),
			longint'(smp.accel_yz), dt, w);
		// with no elapsed time the rates stay as they were
		if (dt != 0) begin
			rate_xz_model = clamp_s16(round_quot(
				(longint'(angle_xz_model) - longint'(prev_xz)) * RATE_SCALE, 2 * dt));
			rate_yz_model = clamp_s16(round_quot(
				(longint'(angle_yz_model) - longint'(prev_yz)) * RATE_SCALE, 2 * dt));
		end
		res.fields.angle_xz = angle_xz_model;
		res.fields.angle_yz = angle_yz_model;
		res.fields.deg_xz   = to_sixtyfourths(angle_xz_model);
		res.fields.deg_yz   = to_sixtyfourths(angle_yz_model);
		res.fields.rate_xz  = rate_xz_model;
		res.fields.rate_yz  = rate_yz_model;
		res.rate_valid      = (dt != 0);
		return res;
	endfunction

	// ------------------------------------------------------------ stimulus

	// Mostly short intervals, some zero, some anywhere in the full range
	function automatic logic [9:0] pick_elapsed();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 10)
			return 10'd0;
		if (sel < 60)
			return 10'($urandom_range(1, 40));
		return 10'($urandom_range(0, 1023));
	endfunction

	// Full-range noise, values that track a given level, small values and extremes
	function automatic logic signed [15:0] pick_value(logic signed [15:0] level);
		int unsigned sel;
		int          offs;
		sel  = $urandom_range(0, 99);
		offs = int'($urandom_range(0, 1023)) - 512;
		if (sel < 50)
			return 16'($urandom);
		if (sel < 75)
			return 16'(int'(level) + offs);
		if (sel < 88)
			return 16'(offs);
		case ($urandom_range(0, 3))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'sh0000;
			default: return -16'sh0001;
		endcase
	endfunction

	// Write blend_gain; call only while no transaction is in flight
	task automatic write_gain(logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gain_model = value;
	endtask

	// Present one sample, hold it until accepted, then record what it must produce.
	// Leave s_tvalid high so that back-to-back samples need no gap.
	task automatic send_sample(imu_sample_t smp, logic pinned, tilt_expect_t pinned_exp);
		tilt_expect_t predicted;
		s_tvalid <= 1'b1;
		s_tdata  <= smp;
		do @(posedge clk); while (!s_tready);
		predicted = advance_tilt_model(smp);
		pending_fusions.push_back(pinned ? pinned_exp : predicted);
	endtask

	task automatic wait_drained();
		while (pending_fusions.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		imu_sample_t  smp;
		tilt_expect_t no_pin;
		logic [15:0]  phase_gain;
		int           burst_left;
		int           gap;
		no_pin = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; change the gain only once the block has gone quiet
		for (int i = 0; i < N_DIRECTED; i++) begin
			if (directed_rows[i].gain != gain_model) begin
				s_tvalid <= 1'b0;
				wait_drained();
				write_gain(directed_rows[i].gain);
			end
			smp.pad        = '0;
			smp.elapsed_ms = directed_rows[i].elapsed_ms;
			smp.gyro_xz    = directed_rows[i].gyro_xz;
			smp.gyro_yz    = directed_rows[i].gyro_yz;
			smp.accel_xz   = directed_rows[i].accel_xz;
			smp.accel_yz   = directed_rows[i].accel_yz;
			send_sample(smp, directed_rows[i].pinned, directed_rows[i].pinned_exp);
		end

		// Random phases, one gain each: both extremes, reset value, tiny, then random
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0:       phase_gain = 16'd0;
				1:       phase_gain = 16'hFFFF;
				2:       phase_gain = GAIN_AT_RESET;
				3:       phase_gain = 16'd1;
				default: phase_gain = 16'($urandom_range(0, 65535));
			endcase
			// hold off the sender until every result is back, then reprogram
			s_tvalid <= 1'b0;
			wait_drained();
			write_gain(phase_gain);
			burst_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					// phase 2 runs without sender gaps; elsewhere mix short and long gaps
					if (ph == 2)
						gap = 0;
					else if ($urandom_range(0, 3) == 0)
						gap = $urandom_range(1, 160);
					else
						gap = $urandom_range(0, 8);
					if (gap > 0) begin
						s_tvalid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				burst_left--;
				smp.pad        = '0;
				smp.elapsed_ms = pick_elapsed();
				smp.gyro_xz    = pick_value(16'sh0000);
				smp.gyro_yz    = pick_value(16'sh0000);
				smp.accel_xz   = pick_value(angle_xz_model);
				smp.accel_yz   = pick_value(angle_yz_model);
				send_sample(smp, 1'b0, no_pin);
			end
		end

		// Drain, then watch a while longer for stray results
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (2 * ITEM_LATENCY) @(posedge clk);
		if (error_count == 0)
			$display("[tilt_complementary_filter] OK");
		else
			$display("[tilt_complementary_filter] ERROR");
		$finish;
	end

	// --------------------------------------------------------- result sink

	// Stall pattern: free-running, coin toss, one in eight, then long stalls
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		case (cycle_count[10:9])
			2'd0:    m_tready <= 1'b1;
			2'd1:    m_tready <= 1'($urandom_range(0, 1));
			2'd2:    m_tready <= (cycle_count[2:0] == 3'd0);
			default: m_tready <= (cycle_count[5:0] < 6'd16);
		endcase
	end

	task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Compare each accepted result with the oldest pending one
	always @(posedge clk) begin : check_results
		tilt_result_t got;
		tilt_expect_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = tilt_result_t'(m_tdata);
			if (pending_fusions.size() == 0) begin
				error_count++;
				$display("%0t ns: unexpected result, expected none, actual %h / %b",
					$time, m_tdata, m_tuser);
			end else begin
				want = pending_fusions.pop_front();
				check_field("angle_xz", want.fields.angle_xz, got.angle_xz);
				check_field("angle_yz", want.fields.angle_yz, got.angle_yz);
				check_field("degrees_xz", want.fields.deg_xz, got.deg_xz);
				check_field("degrees_yz", want.fields.deg_yz, got.deg_yz);
				check_field("derived_rate_xz", want.fields.rate_xz, got.rate_xz);
				check_field("derived_rate_yz", want.fields.rate_yz, got.rate_yz);
				check_field("rate_valid", 16'(want.rate_valid), 16'(m_tuser));
			end
		end
	end

	// Watchdog: drop the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[tilt_complementary_filter] ERROR");
				$finish;
			end
		end
	end

endmodule
